/* rtl/core/sss_pkg.sv */
// Shared types and constants for the stride share scheduler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sss_pkg;

	localparam int SLOTS      = 16;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int ID_W       = 5;
	localparam int KIND_W     = 2;
	localparam int SHARE_W    = 7;
	localparam int STRIDE_ONE = 100000;
	localparam int STEP_W     = $clog2(STRIDE_ONE + 1);
	localparam int PASS_W     = 31;
	localparam int FULL_SHARE = 100;
	localparam int SUM_W      = $clog2(SLOTS * 127 + 1);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int DCNT_W     = $clog2(STEP_W + 1);

	localparam logic [PASS_W-1:0] PASS_LIMIT = {PASS_W{1'b1}};

	typedef enum logic [KIND_W-1:0] {
		REQ_START = 2'd0,
		REQ_END   = 2'd1,
		REQ_RATE  = 2'd2,
		REQ_SCHED = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		SCAN_NONE,
		SCAN_SUM,
		SCAN_MIN,
		SCAN_REBASE
	} scan_op_t;

	typedef enum logic [2:0] {
		SLOT_NONE,
		SLOT_START,
		SLOT_END,
		SLOT_RELEASE,
		SLOT_SET
	} slot_op_t;

	typedef enum logic [1:0] {
		DIV_NONE,
		DIV_RATE,
		DIV_LEFT,
		DIV_EACH
	} div_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RATE_WAIT,
		ST_RD_SCAN,
		ST_RD_TOTAL,
		ST_RD_WAIT_LEFT,
		ST_RD_DIV_EACH,
		ST_RD_WAIT_EACH,
		ST_RD_APPLY,
		ST_SC_SCAN,
		ST_SC_CHECK,
		ST_SC_REBASE,
		ST_SC_ADV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic     load;
		logic     idx_clr;
		logic     acc_clr;
		scan_op_t scan;
		slot_op_t slot;
		div_op_t  div;
		logic     latch_total;
		logic     each_clr;
		logic     each_load;
		logic     apply_share;
		logic     advance;
		logic     reject;
	} dp_cmd_t;

	typedef struct packed {
		req_kind_t kind;
		logic      range_ok;
		logic      rate_reject;
		logic      rate_noop;
		logic      rate_release;
		logic      idx_last;
		logic      div_busy;
		logic      cnt_ok;
		logic      pick_vld;
		logic      overflow;
	} dp_stat_t;

endpackage

/* rtl/core/sss_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on sss_pkg for widths.
`timescale 1ns / 1ps

module sss_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sss_pkg::STEP_W-1:0]  dividend,
	input  logic [sss_pkg::SHARE_W-1:0] divisor,
	output logic                       busy,
	output logic [sss_pkg::STEP_W-1:0]  quotient
);

	logic                        busy_q;
	logic [sss_pkg::DCNT_W-1:0]  cnt_q;
	logic [sss_pkg::STEP_W-1:0]  qd_q;
	logic [sss_pkg::SHARE_W-1:0] rem_q;
	logic [sss_pkg::SHARE_W-1:0] dvs_q;
	logic [sss_pkg::SHARE_W:0]   rem_sh;
	logic                        ge;
	logic [sss_pkg::SHARE_W-1:0] rem_nx;

	always_comb begin
		rem_sh = {rem_q, qd_q[sss_pkg::STEP_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? sss_pkg::SHARE_W'(rem_sh - {1'b0, dvs_q})
			: rem_sh[sss_pkg::SHARE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == sss_pkg::DCNT_W'(sss_pkg::STEP_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			qd_q  <= {qd_q[sss_pkg::STEP_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign busy     = busy_q;
	assign quotient = qd_q;

endmodule

/* rtl/core/sss_dp.sv */
// Datapath: slot table, scan index, accumulators, result registers.
// Depends on sss_pkg and sss_div.
`timescale 1ns / 1ps

module sss_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [sss_pkg::KIND_W-1:0]  req_type,
	input  logic [sss_pkg::ID_W-1:0]    client_id,
	input  logic [sss_pkg::SHARE_W-1:0] rate_percent,
	input  sss_pkg::dp_cmd_t            cmd,
	output sss_pkg::dp_stat_t           stat,
	output logic                        status,
	output logic [sss_pkg::ID_W-1:0]    chosen_client
);

	logic [sss_pkg::KIND_W-1:0]  kind_q;
	logic [sss_pkg::ID_W-1:0]    id_q;
	logic [sss_pkg::SHARE_W-1:0] n_q;

	logic [sss_pkg::SLOTS-1:0]   live_q, rsv_q, run_q;
	logic [sss_pkg::SHARE_W-1:0] share_q [sss_pkg::SLOTS];
	logic [sss_pkg::STEP_W-1:0]  step_q  [sss_pkg::SLOTS];
	logic [sss_pkg::PASS_W-1:0]  pass_q  [sss_pkg::SLOTS];
	logic [sss_pkg::SHARE_W-1:0] total_q;

	logic [sss_pkg::SLOT_W-1:0]  idx_q;
	logic [sss_pkg::SUM_W-1:0]   sum_q;
	logic [sss_pkg::CNT_W-1:0]   cnt_q;
	logic [sss_pkg::SHARE_W-1:0] each_q;
	logic [sss_pkg::SLOT_W-1:0]  pick_q;
	logic                        pick_vld_q;
	logic                        rebased_q;
	logic [sss_pkg::PASS_W-1:0]  base_q;
	logic                        status_q;
	logic [sss_pkg::ID_W-1:0]    chosen_q;

	logic                        live_s, rsv_s;
	logic [sss_pkg::SHARE_W-1:0] share_s;
	logic [sss_pkg::PASS_W-1:0]  pass_s;
	logic [sss_pkg::SHARE_W:0]   ask_sum, ask_lim;
	logic [sss_pkg::SHARE_W-1:0] left;
	logic [sss_pkg::PASS_W:0]    adv_sum;
	logic                        div_start, div_busy;
	logic [sss_pkg::STEP_W-1:0]  dvd, quo;
	logic [sss_pkg::SHARE_W-1:0] dvs;

	always_comb begin
		live_s  = live_q[idx_q];
		rsv_s   = rsv_q[idx_q];
		share_s = share_q[idx_q];
		pass_s  = pass_q[idx_q];
		ask_sum = {1'b0, total_q} + {1'b0, n_q};
		ask_lim = (sss_pkg::SHARE_W+1)'(sss_pkg::FULL_SHARE) + {1'b0, share_s};
		left    = (sum_q <= sss_pkg::SUM_W'(sss_pkg::FULL_SHARE))
			? sss_pkg::SHARE_W'(sss_pkg::SUM_W'(sss_pkg::FULL_SHARE) - sum_q) : '0;
		// pick's own pass is zero once rebased
		adv_sum = {1'b0, (rebased_q ? sss_pkg::PASS_W'(0) : base_q)}
			+ (sss_pkg::PASS_W+1)'(step_q[pick_q]);

		stat.kind         = sss_pkg::req_kind_t'(kind_q);
		stat.range_ok     = (id_q != '0) && (id_q <= sss_pkg::ID_W'(sss_pkg::SLOTS));
		stat.rate_reject  = !live_s
			|| (rsv_s && (n_q != '0) && (ask_sum > ask_lim))
			|| (!rsv_s && ((n_q > sss_pkg::SHARE_W'(sss_pkg::FULL_SHARE))
				|| (ask_sum > (sss_pkg::SHARE_W+1)'(sss_pkg::FULL_SHARE))));
		stat.rate_noop    = !rsv_s && (n_q == '0);
		stat.rate_release = rsv_s && (n_q == '0);
		stat.idx_last     = idx_q == sss_pkg::SLOT_W'(sss_pkg::SLOTS - 1);
		stat.div_busy     = div_busy;
		stat.cnt_ok       = (cnt_q != '0) && (left >= sss_pkg::SHARE_W'(cnt_q));
		stat.pick_vld     = pick_vld_q;
		stat.overflow     = adv_sum[sss_pkg::PASS_W];

		div_start = cmd.div != sss_pkg::DIV_NONE;
		dvd = sss_pkg::STEP_W'(sss_pkg::STRIDE_ONE);
		dvs = n_q;
		case (cmd.div)
			sss_pkg::DIV_LEFT: begin
				dvd = sss_pkg::STEP_W'(left);
				dvs = sss_pkg::SHARE_W'(cnt_q);
			end
			sss_pkg::DIV_EACH: dvs = each_q;
			default: ;
		endcase
	end

	sss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q     <= '0;
			rsv_q      <= '0;
			run_q      <= '0;
			total_q    <= '0;
			idx_q      <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
			pick_vld_q <= 1'b0;
			pick_q     <= '0;
			base_q     <= '0;
			rebased_q  <= 1'b0;
			for (int i = 0; i < sss_pkg::SLOTS; i++) begin
				share_q[i] <= '0;
				step_q[i]  <= '0;
				pass_q[i]  <= '0;
			end
		end else begin
			if (cmd.load)
				idx_q <= sss_pkg::SLOT_W'(client_id - sss_pkg::ID_W'(1));
			if (cmd.acc_clr) begin
				sum_q      <= '0;
				cnt_q      <= '0;
				pick_vld_q <= 1'b0;
				rebased_q  <= 1'b0;
			end

			unique case (cmd.slot)
				sss_pkg::SLOT_START, sss_pkg::SLOT_END: begin
					live_q[idx_q]  <= cmd.slot == sss_pkg::SLOT_START;
					rsv_q[idx_q]   <= 1'b0;
					run_q[idx_q]   <= cmd.slot == sss_pkg::SLOT_START;
					share_q[idx_q] <= '0;
					step_q[idx_q]  <= '0;
				end
				sss_pkg::SLOT_RELEASE: begin
					rsv_q[idx_q]  <= 1'b0;
					pass_q[idx_q] <= '0;
				end
				sss_pkg::SLOT_SET: begin
					rsv_q[idx_q]   <= 1'b1;
					share_q[idx_q] <= n_q;
					step_q[idx_q]  <= quo;
					if (rsv_s)
						pass_q[idx_q] <= '0;
				end
				default: ;
			endcase

			case (cmd.scan)
				sss_pkg::SCAN_SUM: begin
					if (live_s && rsv_s) begin
						sum_q        <= sum_q + sss_pkg::SUM_W'(share_s);
						run_q[idx_q] <= 1'b1;
					end else if (live_s) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				sss_pkg::SCAN_MIN: begin
					if (live_s && run_q[idx_q] && (!pick_vld_q || pass_s < base_q)) begin
						pick_vld_q <= 1'b1;
						pick_q     <= idx_q;
						base_q     <= pass_s;
					end
				end
				sss_pkg::SCAN_REBASE: begin
					rebased_q <= 1'b1;
					if (live_s)
						pass_q[idx_q] <= (pass_s >= base_q) ? pass_s - base_q : '0;
				end
				default: ;
			endcase
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.scan != sss_pkg::SCAN_NONE)
				idx_q <= idx_q + 1'b1;

			if (cmd.latch_total)
				total_q <= sum_q[sss_pkg::SHARE_W-1:0];

			if (cmd.apply_share) begin
				for (int i = 0; i < sss_pkg::SLOTS; i++) begin
					if (live_q[i] && !rsv_q[i]) begin
						share_q[i] <= each_q;
						run_q[i]   <= each_q != '0;
						if (each_q != '0)
							step_q[i] <= quo;
					end
				end
			end

			if (cmd.advance)
				pass_q[pick_q] <= adv_sum[sss_pkg::PASS_W] ? sss_pkg::PASS_LIMIT
					: adv_sum[sss_pkg::PASS_W-1:0];
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= req_type;
			id_q     <= client_id;
			n_q      <= rate_percent;
			status_q <= 1'b0;
			chosen_q <= '0;
		end
		if (cmd.each_clr)
			each_q <= '0;
		else if (cmd.each_load)
			each_q <= quo[sss_pkg::SHARE_W-1:0];
		if (cmd.reject)
			status_q <= 1'b1;
		if (cmd.advance)
			chosen_q <= sss_pkg::ID_W'(pick_q) + sss_pkg::ID_W'(1);
	end

	assign status        = status_q;
	assign chosen_client = chosen_q;

	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= sss_pkg::SHARE_W'(sss_pkg::FULL_SHARE))
		else $error("reserved total above full share");
	a_advance_has_pick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> (pick_vld_q && !adv_sum[sss_pkg::PASS_W]))
		else $error("pass advanced without a valid pick");
	a_apply_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply_share |-> !div_busy)
		else $error("shares applied while a division runs");

endmodule

/* rtl/core/sss_ctrl.sv */
// Controller state machine sequencing datapath commands.
// Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sss_pkg::dp_stat_t stat,
	output sss_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);

	sss_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sss_pkg::ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		done     = 1'b0;
		busy     = state_q != sss_pkg::ST_IDLE;
		unique case (state_q)
			sss_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = sss_pkg::ST_DECODE;
				end
			end
			sss_pkg::ST_DECODE: begin
				if (stat.kind == sss_pkg::REQ_SCHED) begin
					cmd.idx_clr = 1'b1;
					cmd.acc_clr = 1'b1;
					state_nx    = sss_pkg::ST_SC_SCAN;
				end else if (!stat.range_ok) begin
					cmd.reject = 1'b1;
					state_nx   = sss_pkg::ST_DONE;
				end else if (stat.kind == sss_pkg::REQ_RATE) begin
					if (stat.rate_reject) begin
						cmd.reject = 1'b1;
						state_nx   = sss_pkg::ST_DONE;
					end else if (stat.rate_noop) begin
						state_nx = sss_pkg::ST_DONE;
					end else if (stat.rate_release) begin
						cmd.slot    = sss_pkg::SLOT_RELEASE;
						cmd.idx_clr = 1'b1;
						cmd.acc_clr = 1'b1;
						state_nx    = sss_pkg::ST_RD_SCAN;
					end else begin
						cmd.div  = sss_pkg::DIV_RATE;
						state_nx = sss_pkg::ST_RATE_WAIT;
					end
				end else begin
					cmd.slot    = (stat.kind == sss_pkg::REQ_START) ? sss_pkg::SLOT_START
						: sss_pkg::SLOT_END;
					cmd.idx_clr = 1'b1;
					cmd.acc_clr = 1'b1;
					state_nx    = sss_pkg::ST_RD_SCAN;
				end
			end
			sss_pkg::ST_RATE_WAIT: begin
				if (!stat.div_busy) begin
					cmd.slot    = sss_pkg::SLOT_SET;
					cmd.idx_clr = 1'b1;
					cmd.acc_clr = 1'b1;
					state_nx    = sss_pkg::ST_RD_SCAN;
				end
			end
			sss_pkg::ST_RD_SCAN: begin
				cmd.scan = sss_pkg::SCAN_SUM;
				if (stat.idx_last)
					state_nx = sss_pkg::ST_RD_TOTAL;
			end
			sss_pkg::ST_RD_TOTAL: begin
				cmd.latch_total = 1'b1;
				if (stat.cnt_ok) begin
					cmd.div  = sss_pkg::DIV_LEFT;
					state_nx = sss_pkg::ST_RD_WAIT_LEFT;
				end else begin
					cmd.each_clr = 1'b1;
					state_nx     = sss_pkg::ST_RD_APPLY;
				end
			end
			sss_pkg::ST_RD_WAIT_LEFT: begin
				if (!stat.div_busy) begin
					cmd.each_load = 1'b1;
					state_nx      = sss_pkg::ST_RD_DIV_EACH;
				end
			end
			sss_pkg::ST_RD_DIV_EACH: begin
				cmd.div  = sss_pkg::DIV_EACH;
				state_nx = sss_pkg::ST_RD_WAIT_EACH;
			end
			sss_pkg::ST_RD_WAIT_EACH: begin
				if (!stat.div_busy)
					state_nx = sss_pkg::ST_RD_APPLY;
			end
			sss_pkg::ST_RD_APPLY: begin
				cmd.apply_share = 1'b1;
				state_nx        = sss_pkg::ST_DONE;
			end
			sss_pkg::ST_SC_SCAN: begin
				cmd.scan = sss_pkg::SCAN_MIN;
				if (stat.idx_last)
					state_nx = sss_pkg::ST_SC_CHECK;
			end
			sss_pkg::ST_SC_CHECK: begin
				if (!stat.pick_vld) begin
					state_nx = sss_pkg::ST_DONE;
				end else if (stat.overflow) begin
					cmd.idx_clr = 1'b1;
					state_nx    = sss_pkg::ST_SC_REBASE;
				end else begin
					state_nx = sss_pkg::ST_SC_ADV;
				end
			end
			sss_pkg::ST_SC_REBASE: begin
				cmd.scan = sss_pkg::SCAN_REBASE;
				if (stat.idx_last)
					state_nx = sss_pkg::ST_SC_ADV;
			end
			sss_pkg::ST_SC_ADV: begin
				cmd.advance = 1'b1;
				state_nx    = sss_pkg::ST_DONE;
			end
			sss_pkg::ST_DONE: begin
				done     = 1'b1;
				state_nx = sss_pkg::ST_IDLE;
			end
			default: state_nx = sss_pkg::ST_IDLE;
		endcase
	end

	a_done_then_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after result");
	a_take_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request transfer did not raise busy");
	a_div_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div != sss_pkg::DIV_NONE) |-> !stat.div_busy)
		else $error("divider restarted while busy");

endmodule

/* rtl/core/stride_share_scheduler.sv */
// Top level of the stride share scheduler.
// Depends on sss_pkg, sss_ctrl, sss_dp (which holds sss_div).
//
// Usage: a request (req_type, client_id, rate_percent) transfers on a
// rising edge with start high and busy low. busy stays high until the
// result has been shown. The result (status, chosen_client) is valid for
// exactly one cycle while done is high; the receiver cannot stall it, so
// it must sample on that edge.
// Work per request kind, from request transfer to done:
//   schedule, no pass overflow         one 16-slot min scan
//   schedule with pass rebase          plus an extra 16-slot rebase sweep
//   start, end, rate release           16-slot share scan plus two
//                                      divisions (none if no share)
//   rate reservation                   as above plus a third division for
//                                      the stride
//   rejected or no-op requests         decode only
// One request is in flight at a time; a new one is taken only once busy
// has dropped. The slot scans and the bit-serial divider set how long a request takes.
// After reset all slots are empty, passes and shares zero, busy low.
`timescale 1ns / 1ps

module stride_share_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [sss_pkg::KIND_W-1:0]  req_type,
	input  logic [sss_pkg::ID_W-1:0]    client_id,
	input  logic [sss_pkg::SHARE_W-1:0] rate_percent,
	output logic                        done,
	output logic                        status,
	output logic [sss_pkg::ID_W-1:0]    chosen_client
);

	sss_pkg::dp_cmd_t  cmd;
	sss_pkg::dp_stat_t stat;

	sss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	sss_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req_type),
		.client_id     (client_id),
		.rate_percent  (rate_percent),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.chosen_client (chosen_client)
	);

endmodule

/* verif/stride_share_scheduler_checker.sv */
// Checker for the stride share scheduler: watches request and result transfers.
// Keeps its own copy of the slot table, predicts each result and compares it.
// Depends on sss_pkg for the request codes and sizes.
`timescale 1ns / 1ps

module stride_share_scheduler_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [sss_pkg::KIND_W-1:0]  req_type,
	input  logic [sss_pkg::ID_W-1:0]    client_id,
	input  logic [sss_pkg::SHARE_W-1:0] rate_percent,
	input  logic                        done,
	input  logic                        status,
	input  logic [sss_pkg::ID_W-1:0]    chosen_client,
	output int                          fails,
	output int                          pending
);

	localparam longint PASS_MAX = 64'd2147483647;

	typedef struct {
		bit                        st;
		bit [sss_pkg::ID_W-1:0]    chosen;
	} answer_t;

	answer_t                         answers[$];
	bit [sss_pkg::SLOTS-1:0]         live, resv, runnable;
	bit [sss_pkg::SHARE_W-1:0]       share[sss_pkg::SLOTS];
	bit [sss_pkg::STEP_W-1:0]        stride[sss_pkg::SLOTS];
	bit [31:0]                       pass_val[sss_pkg::SLOTS];
	bit [sss_pkg::SHARE_W-1:0]       resv_total;

	function automatic void share_out();
		int total, cnt, left, each;
		total = 0;
		cnt = 0;
		each = 0;
		for (int i = 0; i < sss_pkg::SLOTS; i++) begin
			if (live[i]) begin
				if (resv[i]) begin
					total += share[i];
					runnable[i] = 1'b1;
				end else
					cnt++;
			end
		end
		resv_total = total[sss_pkg::SHARE_W-1:0];
		left = (total <= sss_pkg::FULL_SHARE) ? sss_pkg::FULL_SHARE - total : 0;
		if (cnt > 0 && left >= cnt)
			each = left / cnt;
		for (int i = 0; i < sss_pkg::SLOTS; i++) begin
			if (live[i] && !resv[i]) begin
				share[i] = each[sss_pkg::SHARE_W-1:0];
				if (each > 0) begin
					stride[i] = sss_pkg::STEP_W'(sss_pkg::STRIDE_ONE / each);
					runnable[i] = 1'b1;
				end else
					runnable[i] = 1'b0;
			end
		end
	endfunction

	function automatic bit rate_change(int s, int n);
		if (!live[s])
			return 1'b1;
		if (resv[s]) begin
			if (n == 0) begin
				resv[s] = 1'b0;
				pass_val[s] = '0;
				share_out();
				return 1'b0;
			end
			if (int'(resv_total) + n > sss_pkg::FULL_SHARE + int'(share[s]))
				return 1'b1;
			share[s] = n[sss_pkg::SHARE_W-1:0];
			stride[s] = sss_pkg::STEP_W'(sss_pkg::STRIDE_ONE / n);
			pass_val[s] = '0;
			share_out();
			return 1'b0;
		end
		if (n > sss_pkg::FULL_SHARE || n + int'(resv_total) > sss_pkg::FULL_SHARE)
			return 1'b1;
		if (n == 0)
			return 1'b0;
		resv[s] = 1'b1;
		share[s] = n[sss_pkg::SHARE_W-1:0];
		stride[s] = sss_pkg::STEP_W'(sss_pkg::STRIDE_ONE / n);
		share_out();
		return 1'b0;
	endfunction

	function automatic int pick_next();
		int pick;
		longint base, nxt;
		pick = -1;
		for (int i = 0; i < sss_pkg::SLOTS; i++)
			if (live[i] && runnable[i])
				if (pick < 0 || pass_val[i] < pass_val[pick])
					pick = i;
		if (pick < 0)
			return 0;
		base = pass_val[pick];
		// rebase every live pass on the winner before the advance would overflow
		if (base + stride[pick] > PASS_MAX)
			for (int i = 0; i < sss_pkg::SLOTS; i++)
				if (live[i])
					pass_val[i] = (pass_val[i] >= base)
						? 32'(longint'(pass_val[i]) - base) : '0;
		nxt = longint'(pass_val[pick]) + stride[pick];
		pass_val[pick] = (nxt > PASS_MAX) ? PASS_MAX[31:0] : nxt[31:0];
		return pick + 1;
	endfunction

	function automatic answer_t predict_response(sss_pkg::req_kind_t kind, int id, int n);
		answer_t a;
		int s;
		a.st = 1'b0;
		a.chosen = '0;
		if (kind == sss_pkg::REQ_SCHED)
			a.chosen = sss_pkg::ID_W'(pick_next());
		else if (id == 0 || id > sss_pkg::SLOTS)
			a.st = 1'b1;
		else begin
			s = id - 1;
			case (kind)
				sss_pkg::REQ_START, sss_pkg::REQ_END: begin
					live[s] = (kind == sss_pkg::REQ_START);
					resv[s] = 1'b0;
					runnable[s] = (kind == sss_pkg::REQ_START);
					share[s] = '0;
					stride[s] = '0;
					share_out();
				end
				default: a.st = rate_change(s, n);
			endcase
		end
		return a;
	endfunction

	initial begin
		fails = 0;
		live = '0;
		resv = '0;
		runnable = '0;
		resv_total = '0;
		for (int i = 0; i < sss_pkg::SLOTS; i++) begin
			share[i] = '0;
			stride[i] = '0;
			pass_val[i] = '0;
		end
	end

	assign pending = answers.size();

	always @(posedge clk) begin
		answer_t exp_a;
		if (arst_n) begin
			// results first: a result in this cycle belongs to an older request
			if (done) begin
				if (answers.size() == 0) begin
					fails <= fails + 1;
					if (fails < 10)
						$display("unexpected result: status %0d chosen %0d", status,
							chosen_client);
				end else begin
					exp_a = answers.pop_front();
					if (exp_a.st !== status || exp_a.chosen !== chosen_client) begin
						fails <= fails + 1;
						if (fails < 10)
							$display("result mismatch: exp status %0d chosen %0d, got %0d %0d",
								exp_a.st, exp_a.chosen, status, chosen_client);
					end
				end
			end
			if (start && !busy)
				answers.push_back(predict_response(sss_pkg::req_kind_t'(req_type),
					client_id, rate_percent));
		end
	end

endmodule

/* verif/stride_share_scheduler_test.sv */
// Testbench top for the stride share scheduler: clock, reset, request stimulus.
// Depends on sss_pkg, stride_share_scheduler and stride_share_scheduler_checker.
`timescale 1ns / 1ps

module stride_share_scheduler_test;

	localparam int IDLE_LIMIT = 5000;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [sss_pkg::KIND_W-1:0]   req_type;
	logic [sss_pkg::ID_W-1:0]     client_id;
	logic [sss_pkg::SHARE_W-1:0]  rate_percent;
	logic                         done;
	logic                         status;
	logic [sss_pkg::ID_W-1:0]     chosen_client;
	int                           fails;
	int                           pending;
	int                           idle_cycles;

	stride_share_scheduler uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .client_id(client_id), .rate_percent(rate_percent),
		.done(done), .status(status), .chosen_client(chosen_client)
	);

	stride_share_scheduler_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .client_id(client_id), .rate_percent(rate_percent),
		.done(done), .status(status), .chosen_client(chosen_client),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles with no transfer on either side
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// called at a rising edge; returns at the edge on which the request transfers
	task automatic send_req(sss_pkg::req_kind_t kind, int id, int n);
		start <= 1'b1;
		req_type <= kind;
		client_id <= id[sss_pkg::ID_W-1:0];
		rate_percent <= n[sss_pkg::SHARE_W-1:0];
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic pause_sender(int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int pick_rate();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom_range(1, 30);
		else if (r < 60)
			return 0;
		else if (r < 75)
			return $urandom_range(31, 100);
		else if (r < 85)
			return $urandom_range(101, 127);
		return $urandom_range(0, 127);
	endfunction

	initial begin
		int burst, r, id;
		sss_pkg::req_kind_t kind;
		start <= 1'b0;
		req_type <= sss_pkg::REQ_START;
		client_id <= '0;
		rate_percent <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, range edges, admission limits, release, starved slot
		send_req(sss_pkg::REQ_SCHED, 0, 0);
		send_req(sss_pkg::REQ_START, 0, 0);
		send_req(sss_pkg::REQ_START, 17, 0);
		send_req(sss_pkg::REQ_END, 31, 127);
		send_req(sss_pkg::REQ_RATE, 5, 10);
		send_req(sss_pkg::REQ_END, 5, 0);
		send_req(sss_pkg::REQ_START, 1, 0);
		send_req(sss_pkg::REQ_START, 16, 0);
		send_req(sss_pkg::REQ_RATE, 1, 127);
		send_req(sss_pkg::REQ_RATE, 1, 101);
		send_req(sss_pkg::REQ_RATE, 16, 0);
		send_req(sss_pkg::REQ_RATE, 1, 30);
		send_req(sss_pkg::REQ_START, 16, 0);
		send_req(sss_pkg::REQ_RATE, 1, 60);
		send_req(sss_pkg::REQ_RATE, 16, 80);
		send_req(sss_pkg::REQ_SCHED, 0, 0);
		send_req(sss_pkg::REQ_SCHED, 31, 127);
		send_req(sss_pkg::REQ_RATE, 1, 0);
		send_req(sss_pkg::REQ_START, 2, 0);
		send_req(sss_pkg::REQ_RATE, 2, 100);
		send_req(sss_pkg::REQ_SCHED, 0, 0);
		send_req(sss_pkg::REQ_SCHED, 0, 0);
		send_req(sss_pkg::REQ_END, 1, 0);
		send_req(sss_pkg::REQ_END, 2, 0);
		send_req(sss_pkg::REQ_END, 16, 0);

		// random: bursts of requests with gaps, mostly valid clients
		for (int i = 0; i < 520; i += burst) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst; k++) begin
				r = $urandom_range(0, 9);
				kind = (r < 2) ? sss_pkg::REQ_START : (r < 3) ? sss_pkg::REQ_END :
					(r < 5) ? sss_pkg::REQ_RATE : sss_pkg::REQ_SCHED;
				r = $urandom_range(0, 9);
				id = (r == 0) ? $urandom_range(0, 31) :
					(r < 6) ? $urandom_range(1, 6) : $urandom_range(1, sss_pkg::SLOTS);
				send_req(kind, id, pick_rate());
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 30));
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
